@@ hw/rtl/fem_pkg.sv @@
// Shared types and constants for the file extent to block range mapper.
`default_nettype none
package fem_pkg;
  localparam int MaxChunks   = 1024;
  localparam int MaxResults  = 64;
  localparam int ChunkAw     = $clog2(MaxChunks);
  localparam int CountW      = ChunkAw + 1;
  localparam int ResAw       = $clog2(MaxResults);
  localparam int ResCntW     = ResAw + 1;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_READ   = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NEG_OFF = 3'd1;
  localparam logic [2:0] ST_NOTHING = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  typedef struct packed {
    logic        operation;
    logic        first_chunk;
    logic        chunk_is_data;
    logic [31:0] chunk_block;
    logic [31:0] chunk_block_offset;
    logic [31:0] chunk_length;
    logic [47:0] start_offset;
    logic [31:0] read_size;
    logic [6:0]  max_ranges;
  } item_t;

  typedef struct packed {
    logic        is_data;
    logic [31:0] block;
    logic [32:0] offset;
    logic [31:0] size;
  } range_t;

  typedef struct packed {
    logic               go;
    logic [ResCntW-1:0] count;
    logic [2:0]         fin_status;
    logic               status_only;
  } emit_ctl_t;
endpackage
`default_nettype wire

@@ hw/rtl/file_extent_to_block_range_mapper.sv @@
// Top level of the file extent to block range mapper.
// Usage:
//   Input queue (push/full) takes append and read transactions. Appends load
//   the chunk table, first_chunk restarting it; they give no result.
//   A read walks the table from the first chunk: each chunk takes a table
//   read, then a skip or emit step, with an extra step on the first chunk
//   reached; a hole chunk writes each piece, then closes; status-only answers
//   for a negative offset, zero size or empty table are decided at once.
//   Ranges of a request are collected in a 64-entry result buffer and then
//   released in order on the result queue (empty/pop) while pop stays high,
//   and the last one is flagged with last. The next request starts
//   once the buffer has been drained; a two-entry front queue keeps taking
//   transactions. A stalled receiver (pop low) holds the current result and,
//   once the front queue fills, holds full high.
//   cfg_valid/cfg_ready writes hole_piece_size; cfg_ready is always high.
//   Reset empties the table, both queues and sets hole_piece_size to 65536.
`default_nettype none
module file_extent_to_block_range_mapper
  import fem_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  output logic        full,
  input  wire         in_operation,
  input  wire         in_first_chunk,
  input  wire         in_chunk_is_data,
  input  wire [31:0]  in_chunk_block,
  input  wire [31:0]  in_chunk_block_offset,
  input  wire [31:0]  in_chunk_length,
  input  wire signed [47:0] in_start_offset,
  input  wire [31:0]  in_read_size,
  input  wire [6:0]   in_max_ranges,
  output logic        empty,
  input  wire         pop,
  output logic        out_range_is_data,
  output logic [31:0] out_range_block,
  output logic [32:0] out_range_offset,
  output logic [31:0] out_range_size,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [31:0]  cfg_data
);
  item_t              in_item, q_item;
  logic               q_valid, q_pop;
  logic [31:0]        piece_r;
  logic               wr_en;
  logic [ResAw-1:0]   wr_addr;
  range_t             wr_data, res;
  emit_ctl_t          ctl;
  logic               out_busy;

  assign cfg_ready = 1'b1;
  assign in_item = '{operation: in_operation, first_chunk: in_first_chunk,
                     chunk_is_data: in_chunk_is_data, chunk_block: in_chunk_block,
                     chunk_block_offset: in_chunk_block_offset,
                     chunk_length: in_chunk_length, start_offset: in_start_offset,
                     read_size: in_read_size, max_ranges: in_max_ranges};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piece_r <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      piece_r <= cfg_data;
    end
  end

  fem_front u_front (
    .clk, .rst_n, .push, .full, .in_item,
    .q_valid, .q_pop, .q_item
  );

  fem_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .piece_cfg(piece_r),
    .wr_en, .wr_addr, .wr_data, .ctl, .out_busy
  );

  fem_out u_out (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .ctl, .busy(out_busy),
    .empty, .pop, .res, .status(out_status), .last(out_last)
  );

  assign out_range_is_data = res.is_data;
  assign out_range_block   = res.block;
  assign out_range_offset  = res.offset;
  assign out_range_size    = res.size;
endmodule
`default_nettype wire

@@ hw/rtl/fem_front.sv @@
// Front queue: accepts request transactions and holds them for the walker.
`default_nettype none
module fem_front
  import fem_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  output logic  full,
  input  item_t in_item,
  output logic  q_valid,
  input  wire   q_pop,
  output item_t q_item
);
  item_t       slot_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        do_push;
  logic        do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fem_out.sv @@
// Result buffer: collects ranges of one request and releases them in order.
`default_nettype none
module fem_out
  import fem_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  wire [ResAw-1:0]  wr_addr,
  input  range_t           wr_data,
  input  emit_ctl_t        ctl,
  output logic             busy,
  output logic             empty,
  input  wire              pop,
  output range_t           res,
  output logic [2:0]       status,
  output logic             last
);
  range_t             mem [MaxResults];
  range_t             rd_r;
  logic               busy_r, pend_r, valid_r, last_r, so_r;
  logic [ResCntW-1:0] cnt_r, ptr_r;
  logic [2:0]         fin_r;
  logic               issue;

  assign busy  = busy_r;
  assign empty = !valid_r;
  assign issue = busy_r && !pend_r && !valid_r && (ptr_r < cnt_r);
  assign res   = so_r ? '0 : rd_r;
  assign last  = last_r;
  assign status = last_r ? fin_r : ST_OK;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_r <= mem[ptr_r[ResAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      so_r    <= 1'b0;
      cnt_r   <= '0;
      ptr_r   <= '0;
      fin_r   <= ST_OK;
    end else begin
      if (ctl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.count;
        fin_r  <= ctl.fin_status;
        so_r   <= ctl.status_only;
        ptr_r  <= '0;
      end
      if (issue) begin
        pend_r <= 1'b1;
        ptr_r  <= ptr_r + 1'b1;
      end
      if (pend_r) begin
        pend_r  <= 1'b0;
        valid_r <= 1'b1;
        last_r  <= (ptr_r == cnt_r);
      end
      if (pop && valid_r) begin
        valid_r <= 1'b0;
        if (last_r) busy_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fem_back.sv @@
// Back end: chunk table storage and the read walk that produces ranges.
`default_nettype none
module fem_back
  import fem_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  output logic             q_pop,
  input  item_t            q_item,
  input  wire [31:0]       piece_cfg,
  output logic             wr_en,
  output logic [ResAw-1:0] wr_addr,
  output range_t           wr_data,
  output emit_ctl_t        ctl,
  input  wire              out_busy
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_HOLE = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic              kind_mem  [MaxChunks];
  logic [31:0]       block_mem [MaxChunks];
  logic [31:0]       boff_mem  [MaxChunks];
  logic [31:0]       len_mem   [MaxChunks];
  logic              kind_q;
  logic [31:0]       block_q, boff_q, len_q;

  logic [2:0]         st_r, st_nxt;
  logic [CountW-1:0]  ecnt_r, ecnt_nxt;
  logic [CountW-1:0]  idx_r, idx_nxt;
  logic [47:0]        off_r, off_nxt;
  logic [31:0]        size_r, size_nxt;
  logic [6:0]         maxr_r, maxr_nxt;
  logic [31:0]        nread_r, nread_nxt;
  logic [31:0]        copy_r, copy_nxt;
  logic [ResCntW-1:0] n_r, n_nxt;
  logic [31:0]        pmax;

  logic               app_we;
  logic [ChunkAw-1:0] app_addr;
  logic               rd_en;
  logic [31:0]        chunk_copy, rem, clip, piece;
  logic               n_full, chunk_end;

  assign pmax   = (piece_cfg == 32'd0) ? 32'd1 : piece_cfg;
  assign n_full = (n_r == ResCntW'(MaxResults));
  assign chunk_copy = len_q - off_r[31:0];
  assign rem    = size_r - nread_r;
  assign clip   = (chunk_copy > rem) ? rem : chunk_copy;
  assign piece  = (copy_r < pmax) ? copy_r : pmax;
  assign rd_en  = (st_r == S_RD);

  always_ff @(posedge clk) begin
    if (app_we) begin
      kind_mem[app_addr]  <= q_item.chunk_is_data;
      block_mem[app_addr] <= q_item.chunk_block;
      boff_mem[app_addr]  <= q_item.chunk_block_offset;
      len_mem[app_addr]   <= q_item.chunk_length;
    end
    if (rd_en) begin
      kind_q  <= kind_mem[idx_r[ChunkAw-1:0]];
      block_q <= block_mem[idx_r[ChunkAw-1:0]];
      boff_q  <= boff_mem[idx_r[ChunkAw-1:0]];
      len_q   <= len_mem[idx_r[ChunkAw-1:0]];
    end
  end

  always_comb begin
    st_nxt    = st_r;
    ecnt_nxt  = ecnt_r;
    idx_nxt   = idx_r;
    off_nxt   = off_r;
    size_nxt  = size_r;
    maxr_nxt  = maxr_r;
    nread_nxt = nread_r;
    copy_nxt  = copy_r;
    n_nxt     = n_r;
    q_pop     = 1'b0;
    app_we    = 1'b0;
    app_addr  = ecnt_r[ChunkAw-1:0];
    wr_en     = 1'b0;
    wr_addr   = n_r[ResAw-1:0];
    wr_data   = '0;
    ctl       = '0;
    chunk_end = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.operation == OP_APPEND) begin
            if (q_item.first_chunk) begin
              app_we   = 1'b1;
              app_addr = '0;
              ecnt_nxt = CountW'(1);
            end else if (ecnt_r < CountW'(MaxChunks)) begin
              app_we   = 1'b1;
              ecnt_nxt = ecnt_r + 1'b1;
            end
          end else begin
            off_nxt   = q_item.start_offset;
            size_nxt  = q_item.read_size;
            maxr_nxt  = q_item.max_ranges;
            idx_nxt   = '0;
            nread_nxt = '0;
            n_nxt     = '0;
            if (q_item.start_offset[47]) begin
              ctl    = '{go: 1'b1, count: ResCntW'(1), fin_status: ST_NEG_OFF,
                         status_only: 1'b1};
              st_nxt = S_WAIT;
            end else if (q_item.read_size == 32'd0 || ecnt_r == '0) begin
              ctl    = '{go: 1'b1, count: ResCntW'(1), fin_status: ST_NOTHING,
                         status_only: 1'b1};
              st_nxt = S_WAIT;
            end else begin
              st_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        st_nxt = (n_r == '0) ? S_SKIP : S_WALK;
      end
      S_SKIP: begin
        if (off_r >= {16'd0, len_q}) begin
          off_nxt = off_r - {16'd0, len_q};
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 >= ecnt_r) begin
            ctl    = '{go: 1'b1, count: ResCntW'(1), fin_status: ST_NOTHING,
                       status_only: 1'b1};
            st_nxt = S_WAIT;
          end else begin
            st_nxt = S_RD;
          end
        end else begin
          st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (chunk_copy == 32'd0 || len_q == 32'd0) begin
          ctl    = '{go: 1'b1, count: ResCntW'(1), fin_status: ST_ZERO,
                     status_only: 1'b1};
          st_nxt = S_WAIT;
        end else if (kind_q) begin
          if (n_full) begin
            ctl    = '{go: 1'b1, count: n_r, fin_status: ST_TRUNC,
                       status_only: 1'b0};
            st_nxt = S_WAIT;
          end else begin
            wr_en     = 1'b1;
            wr_data   = '{is_data: 1'b1, block: block_q,
                          offset: {1'b0, boff_q} + {1'b0, off_r[31:0]}, size: clip};
            n_nxt     = n_r + 1'b1;
            nread_nxt = nread_r + clip;
            chunk_end = 1'b1;
          end
        end else begin
          copy_nxt = clip;
          st_nxt   = S_HOLE;
        end
      end
      S_HOLE: begin
        if (copy_r == 32'd0) begin
          chunk_end = 1'b1;
        end else if (n_full) begin
          ctl    = '{go: 1'b1, count: n_r, fin_status: ST_TRUNC, status_only: 1'b0};
          st_nxt = S_WAIT;
        end else begin
          wr_en     = 1'b1;
          wr_data   = '{is_data: 1'b0, block: 32'd0, offset: 33'd0, size: piece};
          n_nxt     = n_r + 1'b1;
          copy_nxt  = copy_r - piece;
          nread_nxt = nread_r + piece;
        end
      end
      S_WAIT: begin
        if (!out_busy) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    if (chunk_end) begin
      off_nxt = '0;
      idx_nxt = idx_r + 1'b1;
      if (nread_nxt == size_r || {1'b0, n_nxt} >= {1'b0, maxr_r} ||
          idx_r + 1'b1 >= ecnt_r) begin
        ctl    = '{go: 1'b1, count: n_nxt, fin_status: ST_OK, status_only: 1'b0};
        st_nxt = S_WAIT;
      end else begin
        st_nxt = S_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ecnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      ecnt_r <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    off_r   <= off_nxt;
    size_r  <= size_nxt;
    maxr_r  <= maxr_nxt;
    nread_r <= nread_nxt;
    copy_r  <= copy_nxt;
    n_r     <= n_nxt;
  end
endmodule
`default_nettype wire

@@ hw/rtl/fem_checker.sv @@
// Port-level checks for the mapper, bound to the top level.
`default_nettype none
module fem_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire        pop,
  input wire [31:0] out_range_size,
  input wire [2:0]  out_status,
  input wire        out_last
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_status <= 3'd4)
    else $error("status code out of range");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != 3'd0) |-> out_last)
    else $error("non-ok status on a non-final result");
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == 3'd1 || out_status == 3'd2 || out_status == 3'd3))
    |-> out_range_size == 32'd0)
    else $error("status-only result carries a size");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_range_size)))
    else $error("waiting result changed");
endmodule

bind file_extent_to_block_range_mapper fem_checker u_fem_checker (
  .clk, .rst_n, .empty, .pop, .out_range_size, .out_status, .out_last
);
`default_nettype wire
